>>> design/dual_axis_half_step_stepper_driver_core_assert.svh
// Assertion macros shared by the stepper driver core.
`ifndef DUAL_AXIS_HALF_STEP_STEPPER_DRIVER_CORE_ASSERT_SVH
`define DUAL_AXIS_HALF_STEP_STEPPER_DRIVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DAHS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stepper driver core: assertion failed");

// Next-cycle implication, disabled during reset.
`define DAHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stepper driver core: assertion failed");

`endif

>>> design/dahs_pkg.sv
`timescale 1ns / 1ps

package dahs_pkg;

  localparam int POSITION_BITS_DEF   = 32;
  localparam int STEP_COUNT_BITS_DEF = 24;

  localparam int HOME_BITS      = 32;
  localparam int STEP_IN_BITS   = 24;
  localparam int POS_OUT_BITS   = 32;
  localparam int REMAIN_BITS    = 24;
  localparam int COIL_BITS      = 4;

  localparam logic signed [HOME_BITS-1:0] HOME_RESET = 32'sd5000;

  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_SET_AZ    = 2'd1,
    FUNC_SET_EL    = 2'd2,
    FUNC_LOAD_HOME = 2'd3
  } func_t;

  localparam logic CFG_HOME_AZ = 1'b0;
  localparam logic CFG_HOME_EL = 1'b1;

  // Per-axis command for one transaction. The tick, set and load flags are zero when
  // nothing advances; the limit inputs simply follow the input register.
  typedef struct packed {
    logic tick;
    logic set_steps;
    logic load_home;
    logic fwd_limit;
    logic back_limit;
  } axis_cmd_t;

  // Half-step coil pattern, bit 0 drives coil 1.
  function automatic logic [COIL_BITS-1:0] coil_pattern(input logic [2:0] phase);
    logic [COIL_BITS-1:0] pat;
    case (phase)
      3'd0:    pat = 4'h9;
      3'd1:    pat = 4'h8;
      3'd2:    pat = 4'hC;
      3'd3:    pat = 4'h4;
      3'd4:    pat = 4'h6;
      3'd5:    pat = 4'h2;
      3'd6:    pat = 4'h3;
      3'd7:    pat = 4'h1;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

>>> design/dahs_axis.sv
`timescale 1ns / 1ps

module dahs_axis
  import dahs_pkg::*;
#(
  parameter int POSITION_BITS   = POSITION_BITS_DEF,
  parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  axis_cmd_t                         cmd,
  input  logic signed [STEP_COUNT_BITS-1:0] steps,
  input  logic signed [POSITION_BITS-1:0]   home,
  output logic [COIL_BITS-1:0]              coils_next,
  output logic signed [POSITION_BITS-1:0]   position_next,
  output logic signed [STEP_COUNT_BITS-1:0] pending_next,
  output logic                              energized_next
);

  logic signed [STEP_COUNT_BITS-1:0] pending;
  logic signed [POSITION_BITS-1:0]   position;
  logic                              energized;

  always_comb begin
    pending_next   = pending;
    position_next  = position;
    energized_next = energized;
    if (cmd.tick) begin
      if (pending == '0) begin
        energized_next = 1'b0;
      end else if (!energized) begin
        // Coils come back on at the held phase before any motion.
        energized_next = 1'b1;
      end else if (!pending[STEP_COUNT_BITS-1]) begin
        if (cmd.fwd_limit) begin
          pending_next = '0;
        end else begin
          position_next = position + POSITION_BITS'(1);
          pending_next  = pending - STEP_COUNT_BITS'(1);
        end
      end else begin
        if (cmd.back_limit) begin
          pending_next = '0;
        end else begin
          position_next = position - POSITION_BITS'(1);
          pending_next  = pending + STEP_COUNT_BITS'(1);
        end
      end
    end
    if (cmd.set_steps) begin
      pending_next = steps;
    end
    if (cmd.load_home) begin
      position_next = home;
    end
  end

  assign coils_next = energized_next ? coil_pattern(position_next[2:0]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      position  <= '0;
      energized <= 1'b0;
    end else begin
      pending   <= pending_next;
      position  <= position_next;
      energized <= energized_next;
    end
  end

endmodule

>>> design/dual_axis_half_step_stepper_driver_core.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in        in_valid/in_ready    func, step_count, four limit switch inputs
// out       out_valid/out_ready  coils, positions and remaining steps per axis
// cfg       cfg_write            cfg_index, cfg_data (home positions)
//
// One transaction per cycle unless the result stalls; an accepted transaction waits in the
// input register and loads the result register when it advances.
// The axis state updates in the same cycle that the result register loads.
// Reset clears both axes and the valid flags and reloads both home positions with 5000.
// A stalled result holds the input register; in_ready falls only when both stages are full.

`include "dual_axis_half_step_stepper_driver_core_assert.svh"

module dual_axis_half_step_stepper_driver_core
  import dahs_pkg::*;
#(
  parameter int POSITION_BITS   = POSITION_BITS_DEF,
  parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     func,
  input  logic signed [STEP_IN_BITS-1:0] step_count,
  input  logic                           left_limit_hit,
  input  logic                           right_limit_hit,
  input  logic                           up_limit_hit,
  input  logic                           down_limit_hit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [COIL_BITS-1:0]           azimuth_coils,
  output logic [COIL_BITS-1:0]           elevation_coils,
  output logic signed [POS_OUT_BITS-1:0] azimuth_position,
  output logic signed [POS_OUT_BITS-1:0] elevation_position,
  output logic signed [REMAIN_BITS-1:0]  azimuth_remaining,
  output logic signed [REMAIN_BITS-1:0]  elevation_remaining,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [HOME_BITS-1:0]           cfg_data
);

  logic signed [HOME_BITS-1:0] home_azimuth;
  logic signed [HOME_BITS-1:0] home_elevation;

  logic                           s1_valid;
  func_t                          s1_func;
  logic signed [STEP_IN_BITS-1:0] s1_step_count;
  logic                           s1_left;
  logic                           s1_right;
  logic                           s1_up;
  logic                           s1_down;

  logic advance;

  axis_cmd_t az_cmd;
  axis_cmd_t el_cmd;

  logic signed [STEP_COUNT_BITS-1:0] steps_ext;
  logic signed [POSITION_BITS-1:0]   home_az_ext;
  logic signed [POSITION_BITS-1:0]   home_el_ext;

  logic [COIL_BITS-1:0]              az_coils_next;
  logic [COIL_BITS-1:0]              el_coils_next;
  logic signed [POSITION_BITS-1:0]   az_position_next;
  logic signed [POSITION_BITS-1:0]   el_position_next;
  logic signed [STEP_COUNT_BITS-1:0] az_pending_next;
  logic signed [STEP_COUNT_BITS-1:0] el_pending_next;
  logic                              az_energized_next;
  logic                              el_energized_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_azimuth   <= HOME_RESET;
      home_elevation <= HOME_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HOME_AZ: home_azimuth   <= cfg_data;
        CFG_HOME_EL: home_elevation <= cfg_data;
        default:     home_azimuth   <= home_azimuth;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func       <= func_t'(func);
      s1_step_count <= step_count;
      s1_left       <= left_limit_hit;
      s1_right      <= right_limit_hit;
      s1_up         <= up_limit_hit;
      s1_down       <= down_limit_hit;
    end
  end

  // Signed size casts sign-extend or wrap into the internal widths.
  assign steps_ext   = STEP_COUNT_BITS'(s1_step_count);
  assign home_az_ext = POSITION_BITS'(home_azimuth);
  assign home_el_ext = POSITION_BITS'(home_elevation);

  always_comb begin
    az_cmd            = '0;
    el_cmd            = '0;
    az_cmd.fwd_limit  = s1_left;
    az_cmd.back_limit = s1_right;
    el_cmd.fwd_limit  = s1_up;
    el_cmd.back_limit = s1_down;
    if (advance) begin
      case (s1_func)
        FUNC_TICK: begin
          az_cmd.tick = 1'b1;
          el_cmd.tick = 1'b1;
        end
        FUNC_SET_AZ: begin
          az_cmd.set_steps = 1'b1;
        end
        FUNC_SET_EL: begin
          el_cmd.set_steps = 1'b1;
        end
        FUNC_LOAD_HOME: begin
          az_cmd.load_home = 1'b1;
          el_cmd.load_home = 1'b1;
        end
        default: begin
          az_cmd.tick = 1'b0;
        end
      endcase
    end
  end

  dahs_axis #(
    .POSITION_BITS   (POSITION_BITS),
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_az_axis (
    .clk            (clk),
    .rst            (rst),
    .cmd            (az_cmd),
    .steps          (steps_ext),
    .home           (home_az_ext),
    .coils_next     (az_coils_next),
    .position_next  (az_position_next),
    .pending_next   (az_pending_next),
    .energized_next (az_energized_next)
  );

  dahs_axis #(
    .POSITION_BITS   (POSITION_BITS),
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_el_axis (
    .clk            (clk),
    .rst            (rst),
    .cmd            (el_cmd),
    .steps          (steps_ext),
    .home           (home_el_ext),
    .coils_next     (el_coils_next),
    .position_next  (el_position_next),
    .pending_next   (el_pending_next),
    .energized_next (el_energized_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      azimuth_coils       <= az_coils_next;
      elevation_coils     <= el_coils_next;
      azimuth_position    <= POS_OUT_BITS'(az_position_next);
      elevation_position  <= POS_OUT_BITS'(el_position_next);
      azimuth_remaining   <= REMAIN_BITS'(az_pending_next);
      elevation_remaining <= REMAIN_BITS'(el_pending_next);
    end
  end

  `DAHS_ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_func))
  `DAHS_ASSERT_NEXT(a_advance_fills_out, clk, rst, advance, out_valid)
  `DAHS_ASSERT_IMPL(a_az_coils_on, clk, rst, advance && az_energized_next, az_coils_next != '0)
  `DAHS_ASSERT_IMPL(a_el_coils_off, clk, rst, advance && !el_energized_next, el_coils_next == '0)

endmodule

>>> tb/dahs_motion_scoreboard.sv
`timescale 1ns / 1ps

module dahs_motion_scoreboard
  import dahs_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     func,
  input  logic signed [STEP_IN_BITS-1:0] step_count,
  input  logic                           left_limit_hit,
  input  logic                           right_limit_hit,
  input  logic                           up_limit_hit,
  input  logic                           down_limit_hit,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [COIL_BITS-1:0]           azimuth_coils,
  input  logic [COIL_BITS-1:0]           elevation_coils,
  input  logic signed [POS_OUT_BITS-1:0] azimuth_position,
  input  logic signed [POS_OUT_BITS-1:0] elevation_position,
  input  logic signed [REMAIN_BITS-1:0]  azimuth_remaining,
  input  logic signed [REMAIN_BITS-1:0]  elevation_remaining,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [HOME_BITS-1:0]           cfg_data,
  output int                             mismatch_count,
  output int                             readouts_due
);

  typedef struct packed {
    logic [STEP_COUNT_BITS_DEF-1:0] pending;
    logic [POSITION_BITS_DEF-1:0]   position;
    logic                           energized;
  } axis_track_t;

  typedef struct packed {
    logic [COIL_BITS-1:0]    az_coils;
    logic [COIL_BITS-1:0]    el_coils;
    logic [POS_OUT_BITS-1:0] az_pos;
    logic [POS_OUT_BITS-1:0] el_pos;
    logic [REMAIN_BITS-1:0]  az_rem;
    logic [REMAIN_BITS-1:0]  el_rem;
  } readout_t;

  // Half-step sequence, phase 0 in the low nibble.
  localparam logic [31:0] HALF_STEP_TABLE = {4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  axis_track_t          az_track;
  axis_track_t          el_track;
  logic [HOME_BITS-1:0] home_az;
  logic [HOME_BITS-1:0] home_el;
  readout_t             expected_readouts[$];

  function automatic axis_track_t tick_axis(axis_track_t a, logic fwd_hit, logic back_hit);
    axis_track_t n;
    n = a;
    if (a.pending == '0) begin
      n.energized = 1'b0;
    end else if (!a.energized) begin
      // The coils come back first; limits are only looked at once they are on.
      n.energized = 1'b1;
    end else if (!a.pending[STEP_COUNT_BITS_DEF-1]) begin
      if (fwd_hit) begin
        n.pending = '0;
      end else begin
        n.position = a.position + 1'b1;
        n.pending  = a.pending - 1'b1;
      end
    end else begin
      if (back_hit) begin
        n.pending = '0;
      end else begin
        n.position = a.position - 1'b1;
        n.pending  = a.pending + 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [COIL_BITS-1:0] coils_for(axis_track_t a);
    return a.energized ? HALF_STEP_TABLE[{a.position[2:0], 2'b00} +: 4] : 4'h0;
  endfunction

  always @(posedge clk) begin
    readout_t exp_r;
    readout_t got_r;
    if (rst) begin
      az_track = '0;
      el_track = '0;
      home_az  = HOME_RESET;
      home_el  = HOME_RESET;
      expected_readouts.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_HOME_AZ) home_az = cfg_data;
        else                          home_el = cfg_data;
      end

      if (in_valid && in_ready) begin
        case (func_t'(func))
          FUNC_TICK: begin
            az_track = tick_axis(az_track, left_limit_hit, right_limit_hit);
            el_track = tick_axis(el_track, up_limit_hit, down_limit_hit);
          end
          FUNC_SET_AZ:    az_track.pending = step_count;
          FUNC_SET_EL:    el_track.pending = step_count;
          FUNC_LOAD_HOME: begin
            az_track.position = home_az;
            el_track.position = home_el;
          end
          default: ;
        endcase
        exp_r.az_coils = coils_for(az_track);
        exp_r.el_coils = coils_for(el_track);
        exp_r.az_pos   = az_track.position;
        exp_r.el_pos   = el_track.position;
        exp_r.az_rem   = az_track.pending;
        exp_r.el_rem   = el_track.pending;
        expected_readouts.push_back(exp_r);
      end

      if (out_valid && out_ready) begin
        got_r.az_coils = azimuth_coils;
        got_r.el_coils = elevation_coils;
        got_r.az_pos   = azimuth_position;
        got_r.el_pos   = elevation_position;
        got_r.az_rem   = azimuth_remaining;
        got_r.el_rem   = elevation_remaining;
        if (expected_readouts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] readout with no command transaction pending", $time);
        end else begin
          exp_r = expected_readouts.pop_front();
          if (got_r !== exp_r) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] readout error: expected coils %h/%h pos %0d/%0d rem %0d/%0d",
                       $time, exp_r.az_coils, exp_r.el_coils, $signed(exp_r.az_pos),
                       $signed(exp_r.el_pos), $signed(exp_r.az_rem), $signed(exp_r.el_rem));
              $display("[%0t]                    got coils %h/%h pos %0d/%0d rem %0d/%0d",
                       $time, got_r.az_coils, got_r.el_coils, $signed(got_r.az_pos),
                       $signed(got_r.el_pos), $signed(got_r.az_rem), $signed(got_r.el_rem));
            end
          end
        end
      end
    end
    readouts_due = expected_readouts.size();
  end

endmodule

>>> tb/tb_dual_axis_half_step_stepper_driver_core.sv
`timescale 1ns / 1ps

module tb_dual_axis_half_step_stepper_driver_core;
  import dahs_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 575;
  localparam int SETTLE_TICKS = 4;

  // Limit switch bundle order: left, right, up, down.
  localparam logic [3:0] LIM_NONE  = 4'b0000;
  localparam logic [3:0] LIM_LEFT  = 4'b1000;
  localparam logic [3:0] LIM_RIGHT = 4'b0100;
  localparam logic [3:0] LIM_UP    = 4'b0010;
  localparam logic [3:0] LIM_DOWN  = 4'b0001;
  localparam logic [3:0] LIM_ALL   = 4'b1111;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     func = FUNC_TICK;
  logic signed [STEP_IN_BITS-1:0] step_count = '0;
  logic                           left_limit_hit = 1'b0;
  logic                           right_limit_hit = 1'b0;
  logic                           up_limit_hit = 1'b0;
  logic                           down_limit_hit = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [COIL_BITS-1:0]           azimuth_coils;
  logic [COIL_BITS-1:0]           elevation_coils;
  logic signed [POS_OUT_BITS-1:0] azimuth_position;
  logic signed [POS_OUT_BITS-1:0] elevation_position;
  logic signed [REMAIN_BITS-1:0]  azimuth_remaining;
  logic signed [REMAIN_BITS-1:0]  elevation_remaining;
  logic                           cfg_write = 1'b0;
  logic                           cfg_index = CFG_HOME_AZ;
  logic [HOME_BITS-1:0]           cfg_data = '0;

  int mismatch_count;
  int readouts_due;
  int sender_idle_pct = 30;
  int receiver_idle_pct = 57;
  int quiet_cycles = 0;

  dual_axis_half_step_stepper_driver_core DUT (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .func                (func),
    .step_count          (step_count),
    .left_limit_hit      (left_limit_hit),
    .right_limit_hit     (right_limit_hit),
    .up_limit_hit        (up_limit_hit),
    .down_limit_hit      (down_limit_hit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .azimuth_coils       (azimuth_coils),
    .elevation_coils     (elevation_coils),
    .azimuth_position    (azimuth_position),
    .elevation_position  (elevation_position),
    .azimuth_remaining   (azimuth_remaining),
    .elevation_remaining (elevation_remaining),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  dahs_motion_scoreboard u_scoreboard (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .func                (func),
    .step_count          (step_count),
    .left_limit_hit      (left_limit_hit),
    .right_limit_hit     (right_limit_hit),
    .up_limit_hit        (up_limit_hit),
    .down_limit_hit      (down_limit_hit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .azimuth_coils       (azimuth_coils),
    .elevation_coils     (elevation_coils),
    .azimuth_position    (azimuth_position),
    .elevation_position  (elevation_position),
    .azimuth_remaining   (azimuth_remaining),
    .elevation_remaining (elevation_remaining),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatch_count      (mismatch_count),
    .readouts_due        (readouts_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input func_t op, input logic [STEP_IN_BITS-1:0] steps,
                           input logic [3:0] limits);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= op;
    step_count <= steps;
    {left_limit_hit, right_limit_hit, up_limit_hit, down_limit_hit} <= limits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (readouts_due != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_homes(input logic [HOME_BITS-1:0] az_home,
                             input logic [HOME_BITS-1:0] el_home);
    cfg_write <= 1'b1;
    cfg_index <= CFG_HOME_AZ;
    cfg_data  <= az_home;
    @(negedge clk);
    cfg_index <= CFG_HOME_EL;
    cfg_data  <= el_home;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [STEP_IN_BITS-1:0] pick_steps();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 70) begin
      v = int'($urandom_range(24)) - 12;
    end else if (r < 80) begin
      v = $urandom;
    end else if (r < 90) begin
      case ($urandom_range(3))
        0:       v = 24'h7FFFFF;
        1:       v = 24'h800000;
        2:       v = 0;
        default: v = -1;
      endcase
    end else begin
      v = int'($urandom_range(2000)) - 1000;
    end
    return v[STEP_IN_BITS-1:0];
  endfunction

  function automatic logic [3:0] sparse_limits();
    logic [3:0] l;
    for (int i = 0; i < 4; i++) l[i] = ($urandom_range(99) < 8);
    return l;
  endfunction

  // Mostly complete moves (set both axes, then a run of ticks), with some stray items.
  task automatic run_moves(input int target);
    int sent;
    int n_ticks;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(9) == 0) begin
          send_item(FUNC_LOAD_HOME, STEP_IN_BITS'($urandom), 4'($urandom));
          sent++;
        end
        send_item(FUNC_SET_AZ, pick_steps(), 4'($urandom));
        send_item(FUNC_SET_EL, pick_steps(), 4'($urandom));
        n_ticks = $urandom_range(3, 24);
        repeat (n_ticks) send_item(FUNC_TICK, STEP_IN_BITS'($urandom), sparse_limits());
        sent += n_ticks + 2;
      end else begin
        send_item(func_t'($urandom_range(3)), STEP_IN_BITS'($urandom), 4'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Idle tick, then a move to the step count extremes cut short by the limits.
    send_item(FUNC_TICK, '0, LIM_ALL);
    send_item(FUNC_LOAD_HOME, '0, LIM_NONE);
    send_item(FUNC_SET_AZ, 24'sh7FFFFF, LIM_NONE);
    send_item(FUNC_SET_EL, 24'sh800000, LIM_NONE);
    send_item(FUNC_TICK, '0, LIM_ALL);
    send_item(FUNC_TICK, '0, LIM_LEFT | LIM_DOWN);
    send_item(FUNC_TICK, '0, LIM_NONE);
    send_item(FUNC_SET_AZ, -24'sd1, LIM_NONE);
    send_item(FUNC_SET_EL, 24'sd1, LIM_NONE);
    send_item(FUNC_TICK, '0, LIM_NONE);
    send_item(FUNC_TICK, '0, LIM_NONE);
    send_item(FUNC_TICK, '0, LIM_NONE);
    send_item(FUNC_SET_AZ, '0, LIM_ALL);
    drain();

    // Homes at the position extremes so a few steps wrap both counters.
    write_homes(32'h7FFFFFFF, 32'h80000000);
    send_item(FUNC_LOAD_HOME, 24'shFFFFFF, LIM_ALL);
    send_item(FUNC_SET_AZ, 24'sd3, LIM_NONE);
    send_item(FUNC_SET_EL, -24'sd3, LIM_NONE);
    repeat (4) send_item(FUNC_TICK, '0, LIM_RIGHT | LIM_UP);
    send_item(FUNC_SET_AZ, -24'sd2, LIM_NONE);
    send_item(FUNC_TICK, '0, LIM_RIGHT);
    send_item(FUNC_TICK, '0, LIM_NONE);
    send_item(FUNC_SET_EL, 24'sd2, LIM_NONE);
    send_item(FUNC_TICK, '0, LIM_UP);
    send_item(FUNC_TICK, '0, LIM_UP);

    run_moves(PHASE_ITEMS);
    drain();

    write_homes($urandom, $urandom);
    sender_idle_pct   = 57;
    receiver_idle_pct = 30;
    run_moves(PHASE_ITEMS);
    drain();

    write_homes('0, 32'hFFFFFFFF);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_moves(PHASE_ITEMS);
    drain();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
